@@ rtl/ptd_pkg.sv @@
// Shared types and constants for the trial-division primality tester.
// No dependencies; imported by every module of the block.
package ptd_pkg;

    // Small-number screen and the 6k +/- 1 wheel
    localparam int PRIME_LOW   = 2;   // below this: not prime
    localparam int PRIME_SMALL = 4;   // 2 and 3 are prime
    localparam int SMALL_LIMIT = 9;   // odd numbers below this are prime
    localparam int TRIAL_THREE = 3;   // first trial divisor
    localparam int F_FIRST     = 5;   // first wheel candidate
    localparam int F_STEP      = 6;   // wheel stride
    localparam int F_GAP       = 2;   // partner candidate offset (f + 2)

    // Result channel payload width (one flag, padded to a byte)
    localparam int OUT_TDATA_W = 8;

    // Control from the sequencer to a remainder lane
    typedef struct packed {
        logic start;   // load divisor, clear remainder
        logic shift;   // take one dividend bit
    } lane_ctl_t;

    // Control from the sequencer to the candidate generator
    typedef struct packed {
        logic load;     // f = 5, f*f = 25
        logic advance;  // f += 6, f*f updated incrementally
    } cand_ctl_t;

endpackage

@@ rtl/ptd_rem_lane.sv @@
// Bit-serial restoring remainder lane: one dividend bit per cycle while shift is high, MSB first.
// Depends on ptd_pkg (lane_ctl_t).
module ptd_rem_lane #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptd_pkg::lane_ctl_t     ctl,
    input  logic [NUMBER_BITS-1:0] divisor,
    input  logic                   bit_in,
    output logic                   rem_zero
);
    import ptd_pkg::*;

    logic [NUMBER_BITS-1:0] div_reg;
    logic [NUMBER_BITS-1:0] rem_reg;
    logic [NUMBER_BITS-1:0] rem_next;
    logic [NUMBER_BITS:0]   trial;

    // Shift in the next bit, subtract the divisor when it fits
    always_comb
    begin
        trial = {rem_reg, bit_in};
        if (trial >= {1'b0, div_reg})
        begin
            trial = trial - {1'b0, div_reg};
        end
        rem_next = trial[NUMBER_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (ctl.start)
        begin
            rem_reg <= '0;
        end
        else if (ctl.shift)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            div_reg <= divisor;
        end
    end

    assign rem_zero = (rem_reg == '0);

endmodule

@@ rtl/ptd_cand.sv @@
// Wheel candidate generator: holds f and f*f, steps f by 6 with an
// incremental square update. Depends on ptd_pkg (constants, cand_ctl_t).
module ptd_cand #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptd_pkg::cand_ctl_t     ctl,
    input  logic [NUMBER_BITS-1:0] number,
    output logic [NUMBER_BITS-1:0] f_lo,
    output logic [NUMBER_BITS-1:0] f_hi,
    output logic                   past_root
);
    import ptd_pkg::*;

    // f*f overshoots n by at most 12*sqrt(n)+36, which fits in 4 extra bits
    localparam int SQ_W = NUMBER_BITS + 4;

    logic [NUMBER_BITS-1:0] f_reg;
    logic [NUMBER_BITS-1:0] f_next;
    logic [SQ_W-1:0]        sq_reg;
    logic [SQ_W-1:0]        sq_next;
    logic [SQ_W-1:0]        f_ext;

    assign f_ext = {4'b0, f_reg};

    always_comb
    begin
        f_next  = f_reg;
        sq_next = sq_reg;
        if (ctl.load)
        begin
            f_next  = NUMBER_BITS'(F_FIRST);
            sq_next = SQ_W'(F_FIRST * F_FIRST);
        end
        else if (ctl.advance)
        begin
            // (f + 6)^2 = f^2 + 12f + 36
            f_next  = f_reg + NUMBER_BITS'(F_STEP);
            sq_next = sq_reg + (f_ext << 3) + (f_ext << 2) + SQ_W'(F_STEP * F_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg  <= '0;
            sq_reg <= '0;
        end
        else
        begin
            f_reg  <= f_next;
            sq_reg <= sq_next;
        end
    end

    assign f_lo      = f_reg;
    assign f_hi      = f_reg + NUMBER_BITS'(F_GAP);
    assign past_root = (sq_reg > {4'b0, number});

endmodule

@@ rtl/primality_trial_division_unit.sv @@
// Primality test by trial division over the 6k +/- 1 wheel.
// Accept to m_tvalid: numbers settled by the small screen (below 9, or even) go from CHECK straight
// to DONE; others run a pass testing 3, then wheel rounds, each a DIV pass over all NUMBER_BITS
// dividend bits and a NEXT step, while f*f <= n. DONE waits until the output register is free.
// Two bit-serial lanes test f and f+2 together. One item at a time: s_tready is high only in IDLE;
// the next item is taken while the result waits. Async reset clears sequencer and m_tvalid.
module primality_trial_division_unit #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((NUMBER_BITS+7)/8)*8-1:0]    s_tdata,   // [NUMBER_BITS-1:0] number
    // Result item stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ptd_pkg::OUT_TDATA_W-1:0]     m_tdata    // [0] is_prime
);
    import ptd_pkg::*;

    localparam int CNT_W = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_NEXT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]             state_reg,  state_next;
    logic [NUMBER_BITS-1:0] n_reg,      n_next;
    logic [NUMBER_BITS-1:0] shift_reg,  shift_next;
    logic [CNT_W-1:0]       cnt_reg,    cnt_next;
    logic                   res_reg,    res_next;
    logic                   mvalid_reg, mvalid_next;
    logic                   mdata_reg,  mdata_next;

    lane_ctl_t              lane_ctl;
    cand_ctl_t              cand_ctl;
    logic [NUMBER_BITS-1:0] div_a;
    logic [NUMBER_BITS-1:0] div_b;
    logic [NUMBER_BITS-1:0] f_lo;
    logic [NUMBER_BITS-1:0] f_hi;
    logic                   past_root;
    logic                   zero_a;
    logic                   zero_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, mdata_reg};

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        lane_ctl    = '0;
        cand_ctl    = '0;
        div_a       = f_lo;
        div_b       = f_hi;

        // Drop the held result once the sink takes it
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next     = s_tdata[NUMBER_BITS-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Small screen: 0/1, 2/3, even, odd below 9
                if (n_reg < NUMBER_BITS'(PRIME_LOW))
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg < NUMBER_BITS'(PRIME_SMALL))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg < NUMBER_BITS'(SMALL_LIMIT))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // First pass tests 3 on both lanes; the wheel starts at 5
                    div_a          = NUMBER_BITS'(TRIAL_THREE);
                    div_b          = NUMBER_BITS'(TRIAL_THREE);
                    lane_ctl.start = 1'b1;
                    cand_ctl.load  = 1'b1;
                    shift_next     = n_reg;
                    cnt_next       = CNT_W'(NUMBER_BITS - 1);
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Feed one dividend bit, MSB first, to both lanes
                lane_ctl.shift = 1'b1;
                shift_next     = shift_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_NEXT:
            begin
                if (zero_a || zero_b)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (past_root)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // Launch f and f+2, then step the wheel for the next round
                    lane_ctl.start   = 1'b1;
                    cand_ctl.advance = 1'b1;
                    shift_next       = n_reg;
                    cnt_next         = CNT_W'(NUMBER_BITS - 1);
                    state_next       = ST_DIV;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = res_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        shift_reg <= shift_next;
        res_reg   <= res_next;
        mdata_reg <= mdata_next;
    end

    ptd_rem_lane #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .divisor  (div_a),
        .bit_in   (shift_reg[NUMBER_BITS-1]),
        .rem_zero (zero_a)
    );

    ptd_rem_lane #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .divisor  (div_b),
        .bit_in   (shift_reg[NUMBER_BITS-1]),
        .rem_zero (zero_b)
    );

    ptd_cand #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_cand (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cand_ctl),
        .number    (n_reg),
        .f_lo      (f_lo),
        .f_hi      (f_hi),
        .past_root (past_root)
    );

endmodule
